// File: rtl/core/assert_macros.svh
// Assertion macros shared by the decompressor RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset
`define ASSERT_AT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition must never be true outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: rtl/core/lzd_pkg.sv
// Shared constants and command types for the LZSS decompressor
package lzd_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int CMD_DEPTH    = 4;
  localparam int COPY_BIAS    = 18;
  localparam int MIN_LEN      = 3;
  localparam int OFFSET_W     = 12;
  localparam int LEN_CODE_W   = 4;
  localparam int LEN_W        = 5;   // holds MIN_LEN + 15
  localparam logic [3:0] TOKENS_PER_FLAG = 4'd8;

  typedef enum logic [1:0] {
    CMD_RESTART,
    CMD_LITERAL,
    CMD_COPY
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                kind;
    logic [OFFSET_W-1:0]      arg;       // literal byte in low bits, or copy offset
    logic [LEN_CODE_W-1:0]    len_code;  // copy length minus MIN_LEN
  } cmd_t;

endpackage

// File: rtl/core/lzd_front.sv
// Token parser: tracks flag bits and turns payload bytes into commands
module lzd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          stream_start_i,
  input  logic          full_i,
  output logic          push_o,
  output lzd_pkg::cmd_t cmd_o
);
  import lzd_pkg::*;

  logic [7:0] flag_q, flag_d;
  logic [3:0] tokens_q, tokens_d;
  logic       pend_q, pend_d;
  logic [7:0] first_q, first_d;

  logic       accept;
  logic [7:0] flag_eff;
  logic [3:0] tokens_eff;
  logic       pend_eff;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  // a stream start wipes token state before the byte is parsed as a flag byte
  assign flag_eff   = stream_start_i ? 8'd0 : flag_q;
  assign tokens_eff = stream_start_i ? 4'd0 : tokens_q;
  assign pend_eff   = stream_start_i ? 1'b0 : pend_q;

  always_comb begin
    flag_d       = flag_q;
    tokens_d     = tokens_q;
    pend_d       = pend_q;
    first_d      = first_q;
    push_o       = 1'b0;
    cmd_o.kind   = CMD_RESTART;
    cmd_o.arg    = '0;
    cmd_o.len_code = '0;
    if (accept) begin
      if (tokens_eff == 4'd0) begin
        flag_d   = in_byte_i;
        tokens_d = TOKENS_PER_FLAG;
        pend_d   = 1'b0;
        push_o   = stream_start_i;
      end else if (pend_eff) begin
        push_o         = 1'b1;
        cmd_o.kind     = CMD_COPY;
        cmd_o.arg      = {in_byte_i[7:4], first_q};
        cmd_o.len_code = in_byte_i[3:0];
        pend_d         = 1'b0;
        flag_d         = flag_eff >> 1;
        tokens_d       = tokens_eff - 4'd1;
      end else if (flag_eff[0]) begin
        push_o     = 1'b1;
        cmd_o.kind = CMD_LITERAL;
        cmd_o.arg  = OFFSET_W'(in_byte_i);
        flag_d     = flag_eff >> 1;
        tokens_d   = tokens_eff - 4'd1;
      end else begin
        first_d = in_byte_i;
        pend_d  = 1'b1;
        flag_d  = flag_eff;
        tokens_d = tokens_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q   <= '0;
      tokens_q <= '0;
      pend_q   <= 1'b0;
      first_q  <= '0;
    end else begin
      flag_q   <= flag_d;
      tokens_q <= tokens_d;
      pend_q   <= pend_d;
      first_q  <= first_d;
    end
  end

endmodule

// File: rtl/core/lzd_cmd_fifo.sv
// Small command queue between the token parser and the output engine
`include "assert_macros.svh"

module lzd_cmd_fifo #(
  parameter int Depth = lzd_pkg::CMD_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lzd_pkg::cmd_t wr_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output lzd_pkg::cmd_t rd_cmd_o
);
  import lzd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o   = (count_q == CntW'(Depth));
  assign valid_o  = (count_q != '0);
  assign rd_cmd_o = slots_q[rd_ptr_q];
  assign do_push  = push_i && !full_o;
  assign do_pop   = pop_i && valid_o;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= wr_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  `ASSERT_NEVER(a_no_overflow, push_i && full_o, "command pushed into full queue")
  `ASSERT_NEVER(a_no_underflow, pop_i && !valid_o, "command popped from empty queue")
  `ASSERT_AT(a_count_range, count_q <= CntW'(Depth), "queue count out of range")

endmodule

// File: rtl/core/lzd_back.sv
// Output engine: history memory, literal output and back-reference copy
`include "assert_macros.svh"

module lzd_back #(
  parameter int WindowDepth = lzd_pkg::WINDOW_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  lzd_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          out_last_o
);
  import lzd_pkg::*;

  localparam int AW    = $clog2(WindowDepth);
  localparam int DistW = AW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LIT,
    ST_READ,
    ST_EMIT
  } state_e;

  state_e           st_q, st_d;
  logic [AW-1:0]    wp_q, wp_d;
  logic             filled_q, filled_d;
  logic [AW-1:0]    src_q, src_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [DistW-1:0] zeros_q, zeros_d;
  logic [7:0]       lit_q, lit_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;
  logic             byp_q, byp_d;
  logic [7:0]       bypd_q, bypd_d;

  logic [7:0]       hist_q [WindowDepth];
  logic [7:0]       rdata_q;

  logic             slot_free, fire, we, re;
  logic [7:0]       wdata, emit_byte;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    d_raw;
  logic [DistW-1:0] copy_dist, wp_ext, zeros_calc;

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  assign slot_free = !out_valid_q || out_ready_i;
  assign fire      = slot_free && ((st_q == ST_LIT) || (st_q == ST_EMIT));

  // distance back to the copy source; zero distance wraps to a full window
  assign d_raw      = wp_q - AW'(COPY_BIAS) - AW'(cmd_i.arg);
  assign copy_dist  = (d_raw == '0) ? DistW'(WindowDepth) : {1'b0, d_raw};
  assign wp_ext     = {1'b0, wp_q};
  assign zeros_calc = (!filled_q && (copy_dist > wp_ext)) ? copy_dist - wp_ext : '0;

  // source before stream start reads as zero; overlap with last write is bypassed
  assign emit_byte = (zeros_q != '0) ? 8'd0 : (byp_q ? bypd_q : rdata_q);
  assign wdata     = (st_q == ST_LIT) ? lit_q : emit_byte;
  assign we        = fire;
  assign raddr     = (st_q == ST_READ) ? src_q : src_q + AW'(1);
  assign re        = (st_q == ST_READ) ||
                     ((st_q == ST_EMIT) && slot_free && (len_q != LEN_W'(1)));

  always_comb begin
    st_d        = st_q;
    wp_d        = wp_q;
    filled_d    = filled_q;
    src_d       = src_q;
    len_d       = len_q;
    zeros_d     = zeros_q;
    lit_d       = lit_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    byp_d       = byp_q;
    bypd_d      = bypd_q;
    pop_o       = 1'b0;

    if (re) begin
      byp_d  = we && (raddr == wp_q);
      bypd_d = wdata;
    end

    if (fire) begin
      out_valid_d = 1'b1;
      out_byte_d  = wdata;
      wp_d        = wp_q + AW'(1);
      if (wp_q == '1) begin
        filled_d = 1'b1;
      end
    end

    case (st_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          case (cmd_i.kind)
            CMD_RESTART: begin
              wp_d     = '0;
              filled_d = 1'b0;
            end
            CMD_LITERAL: begin
              lit_d = cmd_i.arg[7:0];
              st_d  = ST_LIT;
            end
            CMD_COPY: begin
              src_d   = AW'(cmd_i.arg) + AW'(COPY_BIAS);
              len_d   = LEN_W'(cmd_i.len_code) + LEN_W'(MIN_LEN);
              zeros_d = zeros_calc;
              st_d    = (zeros_calc != '0) ? ST_EMIT : ST_READ;
            end
            default: begin
              st_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_LIT: begin
        if (fire) begin
          out_last_d = 1'b1;
          st_d       = ST_IDLE;
        end
      end
      ST_READ: begin
        st_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (fire) begin
          out_last_d = (len_q == LEN_W'(1));
          src_d      = src_q + AW'(1);
          len_d      = len_q - LEN_W'(1);
          if (zeros_q != '0) begin
            zeros_d = zeros_q - DistW'(1);
          end
          if (len_q == LEN_W'(1)) begin
            st_d = ST_IDLE;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      hist_q[wp_q] <= wdata;
    end
    if (re) begin
      rdata_q <= hist_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      wp_q        <= '0;
      filled_q    <= 1'b0;
      src_q       <= '0;
      len_q       <= '0;
      zeros_q     <= '0;
      lit_q       <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
      byp_q       <= 1'b0;
      bypd_q      <= '0;
    end else begin
      st_q        <= st_d;
      wp_q        <= wp_d;
      filled_q    <= filled_d;
      src_q       <= src_d;
      len_q       <= len_d;
      zeros_q     <= zeros_d;
      lit_q       <= lit_d;
      out_valid_q <= out_valid_d;
      out_byte_q  <= out_byte_d;
      out_last_q  <= out_last_d;
      byp_q       <= byp_d;
      bypd_q      <= bypd_d;
    end
  end

  `ASSERT_AT(a_read_then_emit, (st_q == ST_READ) |=> (st_q == ST_EMIT), "read not followed by emit")
  `ASSERT_AT(a_emit_len, (st_q == ST_EMIT) |-> (len_q != '0), "emit with zero length left")
  `ASSERT_AT(a_wp_step, fire |=> (wp_q == AW'($past(wp_q) + AW'(1))), "write position skipped")

endmodule

// File: rtl/core/lzss_decompressor.sv
// LZSS decompressor top level: token parser, command queue, output engine
//
//   channel   dir  tdata            tuser / tlast
//   s_axis    in   in_byte [7:0]    tuser: stream_start
//   m_axis    out  out_byte [7:0]   tlast: run_last
//
// Parser takes one byte per cycle while the command queue has room.
// Literal: the engine pops it, then emits it. Copy of length L: the engine
// pops it, reads history (skipped when it opens with zero fill), then emits
// L bytes, one byte per cycle while the output does not stall, through the single history read port.
// History memory is not cleared after reset; the engine only uses entries
// the current stream has written. Output stalls hold the engine; once the
// command queue is full, s_axis_tready drops.
module lzss_decompressor #(
  parameter int WindowDepth = lzd_pkg::WINDOW_DEPTH,
  parameter int CmdDepth    = lzd_pkg::CMD_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tuser_i,   // [0] stream_start
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o
);
  import lzd_pkg::*;

  logic full, push, cmd_valid, pop;
  cmd_t wr_cmd, rd_cmd;

  lzd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .in_byte_i      (s_axis_tdata_i),
    .stream_start_i (s_axis_tuser_i),
    .full_i         (full),
    .push_o         (push),
    .cmd_o          (wr_cmd)
  );

  lzd_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wr_cmd_i (wr_cmd),
    .full_o   (full),
    .pop_i    (pop),
    .valid_o  (cmd_valid),
    .rd_cmd_o (rd_cmd)
  );

  lzd_back #(
    .WindowDepth (WindowDepth)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (rd_cmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

// File: sim/lzss_decompressor_test.sv
// Self-checking testbench for the LZSS decompressor: byte-level decode predictor, paced streams
`timescale 1ns / 100ps

module lzss_decompressor_test;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int RAND_ITEMS = 30;
  localparam int WIN = lzd_pkg::WINDOW_DEPTH;

  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_PERIODIC} rx_mode_e;

  // Decode predictor plus the queue of output bytes still owed by the block
  class decode_scoreboard;
    bit [7:0]  window[];
    bit [7:0]  flag_reg;
    bit [3:0]  tok_left;
    bit        ref_wait;
    bit [7:0]  ref_lo_byte;
    bit [11:0] wr_pos;
    bit        wrapped;
    bit [7:0]  want_byte[$];
    bit        want_last[$];
    int n_fail, n_in, n_out, n_streams, n_refs, n_zero_refs, n_wraps;

    function new();
      window = new[WIN];
    endfunction

    function void push_byte(bit [7:0] b);
      window[wr_pos] = b;
      wr_pos++;
      if (wr_pos == 0) begin
        wrapped = 1'b1;
        n_wraps++;
      end
      want_byte.push_back(b);
      want_last.push_back(1'b0);
      n_out++;
    endfunction

    // One accepted payload byte: advance the token parser, queue the bytes it decodes
    function void take_payload_byte(bit [7:0] b, bit st);
      bit [11:0] ofs;
      bit [11:0] src;
      int len;
      int back_dist;
      int zeros;
      int out_before;
      out_before = n_out;
      n_in++;
      if (st) begin
        flag_reg = '0;
        tok_left = '0;
        ref_wait = 1'b0;
        ref_lo_byte = '0;
        wr_pos = '0;
        wrapped = 1'b0;
        n_streams++;
      end
      if (tok_left == 0) begin
        flag_reg = b;
        tok_left = 4'd8;
      end else if (ref_wait) begin
        ofs = {b[7:4], ref_lo_byte};
        len = b[3:0] + lzd_pkg::MIN_LEN;
        back_dist = (int'(wr_pos) - lzd_pkg::COPY_BIAS - int'(ofs)) & (WIN - 1);
        if (back_dist == 0) back_dist = WIN;
        // source before the stream start reads as zero until it reaches byte 0
        zeros = (!wrapped && back_dist > int'(wr_pos)) ? back_dist - int'(wr_pos) : 0;
        if (zeros > 0) n_zero_refs++;
        src = 12'((int'(wr_pos) - back_dist) & (WIN - 1));
        repeat (len) begin
          if (zeros > 0) begin
            push_byte(8'h00);
            zeros--;
          end else begin
            push_byte(window[src]);
          end
          src++;
        end
        n_refs++;
        ref_wait = 0;
        flag_reg = flag_reg >> 1;
        tok_left--;
      end else if (flag_reg[0]) begin
        push_byte(b);
        flag_reg = flag_reg >> 1;
        tok_left--;
      end else begin
        ref_lo_byte = b;
        ref_wait = 1'b1;
      end
      if (n_out > out_before) want_last[want_last.size() - 1] = 1'b1;
    endfunction

    function void check_out_byte(logic [7:0] d, logic l);
      bit [7:0] eb;
      bit el;
      if (want_byte.size() == 0) begin
        $error("unexpected output byte %02h with no decode pending", d);
        n_fail++;
      end else begin
        eb = want_byte.pop_front();
        el = want_last.pop_front();
        if (d !== eb) begin
          $error("out_byte mismatch: expected %02h, got %02h", eb, d);
          n_fail++;
        end
        if (l !== el) begin
          $error("run_last mismatch: expected %0b, got %0b", el, l);
          n_fail++;
        end
      end
    endfunction

    function void check_drained();
      if (want_byte.size() != 0) begin
        $error("%0d decoded bytes never came out", want_byte.size());
        n_fail++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = 8'h00;   // [7:0] in_byte
  logic       s_axis_tuser_i = 1'b0;    // [0] stream_start
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;           // [7:0] out_byte
  logic       m_axis_tlast_o;           // run_last

  decode_scoreboard sb = new();
  int cycle_count = 0;
  int hold_reqs = 0;
  int burst_left = 0;
  int items_sent = 0;

  lzss_decompressor dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: checks every output transaction, stalls on its own pattern
  initial begin
    rx_mode_e mode;
    int mode_left;
    int hold_left;
    int holds_taken;
    mode = RX_OPEN;
    mode_left = 0;
    hold_left = 0;
    holds_taken = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o === 1'b1 && m_axis_tready_i)
        sb.check_out_byte(m_axis_tdata_o, m_axis_tlast_o);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (holds_taken < hold_reqs) begin
        // long hold-off: the command queue fills and input backs up
        holds_taken++;
        hold_left = HOLD_CYCLES - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_e'($urandom_range(3));
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   m_axis_tready_i <= 1'b1;
          RX_COIN:   m_axis_tready_i <= 1'($urandom_range(1));
          RX_MOSTLY: m_axis_tready_i <= ($urandom_range(3) != 0);
          default:   m_axis_tready_i <= (mode_left % 5) != 0;
        endcase
      end
    end
  end

  // Offer one byte, wait for the transaction, then apply burst/gap pacing
  task automatic send_item(input bit [7:0] b, input bit st);
    int gap;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= b;
    s_axis_tuser_i <= st;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.take_payload_byte(b, st);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
  endtask

  // Well-formed stream: flag groups with literals and back-references.
  // Most references point into what the stream has already produced (within span).
  task automatic send_stream(input int n_tok, input int lit_pct, input int span,
                             input int len_code);
    bit [7:0] flag;
    bit first;
    int out_cnt;
    int k;
    int d;
    int ofs;
    int lc;
    first = 1'b1;
    out_cnt = 0;
    while (n_tok > 0) begin
      k = (n_tok < 8) ? n_tok : 8;
      for (int i = 0; i < 8; i++) flag[i] = ($urandom_range(99) < lit_pct);
      send_item(flag, first);
      first = 1'b0;
      for (int i = 0; i < k; i++) begin
        if (flag[i]) begin
          send_item(8'($urandom), 1'b0);
          out_cnt++;
        end else begin
          lc = (len_code < 0) ? $urandom_range(15) : len_code;
          if (out_cnt > 0 && $urandom_range(9) != 0)
            d = $urandom_range(1, (out_cnt < span) ? out_cnt : span);
          else
            d = $urandom_range(1, WIN);
          ofs = (out_cnt - lzd_pkg::COPY_BIAS - d) & (WIN - 1);
          send_item(ofs[7:0], 1'b0);
          send_item({ofs[11:8], lc[3:0]}, 1'b0);
          out_cnt += lc + lzd_pkg::MIN_LEN;
        end
      end
      n_tok -= k;
    end
  endtask

  initial begin
    int start_items;
    int r;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // flag: two literals then six references
    send_item(8'h03, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    // distance 1, length 18: copy overlaps its own output
    send_item(8'hEF, 1'b0);
    send_item(8'hFF, 1'b0);
    // distance 25 at position 20: five zeros, then runs into byte 0 of the stream
    send_item(8'hE9, 1'b0);
    send_item(8'hFF, 1'b0);
    // offset equal to position minus bias: full-window distance, all zeros, length 3
    send_item(8'h14, 1'b0);
    send_item(8'h00, 1'b0);
    // smallest offset
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0);
    // largest offset
    send_item(8'hFF, 1'b0);
    send_item(8'hF0, 1'b0);
    // smallest offset with longest length
    send_item(8'h00, 1'b0);
    send_item(8'h0F, 1'b0);
    // all-reference flag, then a new stream cuts in after the first reference byte
    send_item(8'h00, 1'b1);
    send_item(8'h10, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'h5A, 1'b0);
    send_item(8'hA5, 1'b0);

    hold_reqs++;
    start_items = items_sent;
    while (items_sent - start_items < RAND_ITEMS) begin
      r = $urandom_range(99);
      if (r < 70) begin
        send_stream($urandom_range(2, 10), $urandom_range(100), $urandom_range(1, 300), -1);
      end else if (r < 85) begin
        // noise: raw bytes, stream starts scattered in
        send_item(8'($urandom), 1'b1);
        repeat ($urandom_range(2, 8)) send_item(8'($urandom), $urandom_range(7) == 0);
      end else begin
        // short stream with a dangling trailing byte
        send_stream($urandom_range(1, 6), 50, 16, -1);
        send_item(8'($urandom), 1'b0);
      end
    end

    // long stream of longest copies so the write position wraps the window
    hold_reqs++;
    send_stream(236, 0, WIN, 15);
    s_axis_tvalid_i <= 1'b0;

    while (sb.want_byte.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.check_drained();

    $display("Run covered %0d payload bytes over %0d streams, %0d decoded bytes,",
             sb.n_in, sb.n_streams, sb.n_out);
    $display("%0d back-references (%0d opening with zero fill), %0d window wraps, %0d cycles",
             sb.n_refs, sb.n_zero_refs, sb.n_wraps, cycle_count);
    if (sb.n_fail == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
